@@ src/f2uf_pkg.sv @@
// ----------------------------------------------------------------------------
// f2uf_pkg: shared types and defaults for the float to unsigned fixed converter
// Class tags, work kinds passed from front to back, and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package f2uf_pkg;

    localparam int EXP_WIDTH_DEF  = 8;
    localparam int FRAC_WIDTH_DEF = 23;
    localparam int OUT_LSB_DEF    = -8;
    localparam int OUT_MSB_DEF    = 15;

    // front/back decoupling queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CLS_ZERO   = 2'd0,
        CLS_NORMAL = 2'd1,
        CLS_INF    = 2'd2,
        CLS_NAN    = 2'd3
    } class_t;

    // what the back end has to produce for a request
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_SAT  = 2'd1,
        KIND_NORM = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  round_en;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

endpackage

`default_nettype wire

@@ src/f2uf_in_if.sv @@
// ----------------------------------------------------------------------------
// f2uf_in_if: input request channel
// Valid/ready channel carrying one floating-point word.
// ----------------------------------------------------------------------------
`default_nettype none

interface f2uf_in_if #(
    parameter int EXP_WIDTH  = 8,
    parameter int FRAC_WIDTH = 23
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            class_tag;
    logic                  sign_bit;
    logic [EXP_WIDTH-1:0]  biased_exponent;
    logic [FRAC_WIDTH-1:0] fraction;

    modport source (
        output valid, class_tag, sign_bit, biased_exponent, fraction,
        input  ready
    );

    modport sink (
        input  valid, class_tag, sign_bit, biased_exponent, fraction,
        output ready
    );
endinterface

`default_nettype wire

@@ src/f2uf_out_if.sv @@
// ----------------------------------------------------------------------------
// f2uf_out_if: output request channel
// Valid/ready channel carrying one unsigned fixed-point result.
// ----------------------------------------------------------------------------
`default_nettype none

interface f2uf_out_if #(
    parameter int WIDTH = 24
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] fixed_value;

    modport source (
        output valid, fixed_value,
        input  ready
    );

    modport sink (
        input  valid, fixed_value,
        output ready
    );
endinterface

`default_nettype wire

@@ src/f2uf_front.sv @@
// ----------------------------------------------------------------------------
// f2uf_front: request intake and classification
// Holds the rounding mode, sorts each request into zero / saturate / shift
// and computes the left shift of 1.fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module f2uf_front import f2uf_pkg::*; #(
    parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
    parameter int FRAC_WIDTH = FRAC_WIDTH_DEF,
    parameter int OUT_LSB    = OUT_LSB_DEF,
    parameter int OUT_MSB    = OUT_MSB_DEF,
    localparam int WIDTH     = OUT_MSB - OUT_LSB + 1,
    localparam int SHIFT_W   = $clog2(WIDTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    f2uf_in_if.sink                  in_ch,
    input  wire logic                q_ready,
    output logic                     q_push,
    output ctl_t                     q_ctl,
    output logic [FRAC_WIDTH:0]      q_mant,
    output logic [SHIFT_W-1:0]       q_shift
);

    localparam int CW   = EXP_WIDTH + 9;
    localparam int BIAS = (1 << (EXP_WIDTH - 1)) - 1;
    localparam logic signed [CW-1:0] MIN_EXP_C = CW'(OUT_LSB - 1 + BIAS);
    localparam logic signed [CW-1:0] WIDTH_C   = CW'(WIDTH);

    logic truncate_mode_reg;
    logic truncate_mode_next;

    class_t               cls;
    logic signed [CW-1:0] e_ext;
    logic signed [CW-1:0] diff;
    kind_t                kind;

    assign truncate_mode_next = cfg_wr_en ? cfg_wr_data : truncate_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            truncate_mode_reg <= 1'b0;
        end
        else
        begin
            truncate_mode_reg <= truncate_mode_next;
        end
    end

    assign cls   = class_t'(in_ch.class_tag);
    assign e_ext = signed'({{(CW - EXP_WIDTH){1'b0}}, in_ch.biased_exponent});
    // shift amount of 1.fraction; below 0 underflows, above WIDTH overflows
    assign diff  = e_ext - MIN_EXP_C;

    always_comb
    begin
        case (cls)
            CLS_NORMAL:
            begin
                if (in_ch.sign_bit || diff < 0)
                    kind = KIND_ZERO;
                else if (diff > WIDTH_C)
                    kind = KIND_SAT;
                else
                    kind = KIND_NORM;
            end
            CLS_INF:
            begin
                kind = in_ch.sign_bit ? KIND_ZERO : KIND_SAT;
            end
            default:
            begin
                kind = KIND_ZERO;
            end
        endcase
    end

    assign in_ch.ready    = q_ready;
    assign q_push         = in_ch.valid && q_ready;
    assign q_ctl.kind     = kind;
    assign q_ctl.round_en = !truncate_mode_reg;
    assign q_mant         = {1'b1, in_ch.fraction};
    assign q_shift        = diff[SHIFT_W-1:0];

endmodule

`default_nettype wire

@@ src/f2uf_queue.sv @@
// ----------------------------------------------------------------------------
// f2uf_queue: short FIFO between front and back
// Register-based, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
`default_nettype none

module f2uf_queue import f2uf_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   ready,
    input  wire logic              pop,
    output logic                   valid,
    output logic [DATA_W-1:0]      data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign ready = (count_reg != FULL_CNT);
    assign valid = (count_reg != '0);
    assign data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // callers must respect ready/valid
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

@@ src/f2uf_back.sv @@
// ----------------------------------------------------------------------------
// f2uf_back: shift, round and result register
// Shifts 1.fraction into place, rounds to nearest (ties down) or truncates,
// saturates on a saturate request or a rounding carry, and holds the result for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module f2uf_back import f2uf_pkg::*; #(
    parameter int FRAC_WIDTH = FRAC_WIDTH_DEF,
    parameter int OUT_LSB    = OUT_LSB_DEF,
    parameter int OUT_MSB    = OUT_MSB_DEF,
    localparam int WIDTH     = OUT_MSB - OUT_LSB + 1,
    localparam int SHIFT_W   = $clog2(WIDTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire ctl_t                q_ctl,
    input  wire logic [FRAC_WIDTH:0] q_mant,
    input  wire logic [SHIFT_W-1:0]  q_shift,
    output logic                     q_pop,
    f2uf_out_if.source               out_ch
);

    localparam int VW = FRAC_WIDTH + 1 + WIDTH;

    logic [VW-1:0]    shifted;
    logic [WIDTH-1:0] q_int;
    logic             rnd_up;
    logic [WIDTH:0]   q_inc;
    logic [WIDTH-1:0] result;

    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg;

    // 1.fraction << shift; integer part above bit FRAC_WIDTH, remainder at and below it
    assign shifted = {{WIDTH{1'b0}}, q_mant} << q_shift;
    assign q_int   = shifted[VW-1:FRAC_WIDTH+1];
    // remainder strictly above one half
    assign rnd_up  = q_ctl.round_en && shifted[FRAC_WIDTH] && (|shifted[FRAC_WIDTH-1:0]);
    assign q_inc   = {1'b0, q_int} + {{WIDTH{1'b0}}, rnd_up};

    always_comb
    begin
        case (q_ctl.kind)
            KIND_SAT:  result = '1;
            KIND_NORM: result = q_inc[WIDTH] ? '1 : q_inc[WIDTH-1:0];
            default:   result = '0;
        endcase
    end

    assign q_pop          = q_valid && (!out_valid_reg || out_ch.ready);
    assign out_valid_next = q_pop || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_data_reg <= result;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.fixed_value = out_data_reg;

endmodule

`default_nettype wire

@@ src/float_to_unsigned_fixed.sv @@
// ----------------------------------------------------------------------------
// float_to_unsigned_fixed: floating-point word to saturated unsigned fixed point
// Dataflow: an accepted request is written into the queue, then into the
// result register, from which the sink takes it once it is ready.
// Throughput: one request per cycle while the sink keeps ready high.
// A 2-entry queue decouples intake from the result register, so input keeps
// flowing for two requests while the sink stalls.
// Reset: rst_n async active low; clears queue, result valid and truncate_mode.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_unsigned_fixed import f2uf_pkg::*; #(
    parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
    parameter int FRAC_WIDTH = FRAC_WIDTH_DEF,
    parameter int OUT_LSB    = OUT_LSB_DEF,
    parameter int OUT_MSB    = OUT_MSB_DEF,
    localparam int WIDTH     = OUT_MSB - OUT_LSB + 1,
    localparam int SHIFT_W   = $clog2(WIDTH + 1)
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    // rounding mode register: 1 truncates, 0 rounds to nearest with ties down
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data,
    f2uf_in_if.sink     in_ch,
    f2uf_out_if.source  out_ch
);

    // queue entry: control, then mantissa, then shift amount
    localparam int QDATA_W = CTL_W + FRAC_WIDTH + 1 + SHIFT_W;

    // front -> queue
    logic                 f_push;
    ctl_t                 f_ctl;
    logic [FRAC_WIDTH:0]  f_mant;
    logic [SHIFT_W-1:0]   f_shift;
    logic                 q_ready;

    // queue -> back
    logic                 q_valid;
    logic                 q_pop;
    logic [QDATA_W-1:0]   q_data;
    ctl_t                 b_ctl;
    logic [FRAC_WIDTH:0]  b_mant;
    logic [SHIFT_W-1:0]   b_shift;

    // Front: classifies every request in the cycle it arrives. Zero, NaN,
    // negatives and underflow become KIND_ZERO; +inf and exponent overflow
    // become KIND_SAT; the rest carry a shift of 0..WIDTH.
    f2uf_front #(
        .EXP_WIDTH  (EXP_WIDTH),
        .FRAC_WIDTH (FRAC_WIDTH),
        .OUT_LSB    (OUT_LSB),
        .OUT_MSB    (OUT_MSB)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .q_ready     (q_ready),
        .q_push      (f_push),
        .q_ctl       (f_ctl),
        .q_mant      (f_mant),
        .q_shift     (f_shift)
    );

    // Queue: lets the front keep accepting while the result register stalls.
    f2uf_queue #(
        .DATA_W (QDATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_ctl, f_mant, f_shift}),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    assign {b_ctl, b_mant, b_shift} = q_data;

    // Back: barrel shift, round-up on remainder above one half unless truncating,
    // saturation on carry out or a saturate request, then the registered output stage.
    f2uf_back #(
        .FRAC_WIDTH (FRAC_WIDTH),
        .OUT_LSB    (OUT_LSB),
        .OUT_MSB    (OUT_MSB)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ctl   (b_ctl),
        .q_mant  (b_mant),
        .q_shift (b_shift),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the float to unsigned fixed converter
// Feeds float words over the input channel, predicts each saturated fixed
// result in both rounding modes, and checks results in order at the output.
// ----------------------------------------------------------------------------

module tb_top;
    import f2uf_pkg::*;

    localparam int EXP_W   = EXP_WIDTH_DEF;
    localparam int FRAC_W  = FRAC_WIDTH_DEF;
    localparam int OUT_LO  = OUT_LSB_DEF;
    localparam int OUT_HI  = OUT_MSB_DEF;
    localparam int WIDTH   = OUT_HI - OUT_LO + 1;
    localparam int BIAS    = (1 << (EXP_W - 1)) - 1;
    // exponent window that lands inside the output bits
    localparam int MIN_EXP = OUT_LO - 1 + BIAS;
    localparam int MAX_EXP = OUT_HI + BIAS;

    localparam int SETTLE_CYCLES = 8;      // settle margin after the last result
    localparam int HOLD_CYCLES   = 64;     // long output back-pressure stretch
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 10;

    localparam bit MODE_ROUND    = 1'b0;
    localparam bit MODE_TRUNCATE = 1'b1;

    typedef struct packed {
        class_t              cls;
        logic                sgn;
        logic [EXP_W-1:0]    expo;
        logic [FRAC_W-1:0]   frac;
    } float_word_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    f2uf_in_if  #(.EXP_WIDTH(EXP_W), .FRAC_WIDTH(FRAC_W)) in_ch ();
    f2uf_out_if #(.WIDTH(WIDTH))                          out_ch ();

    float_to_unsigned_fixed uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // float words waiting to be offered, and fixed values owed by the block
    float_word_t      float_pending_q[$];
    logic [WIDTH-1:0] fixed_expected_q[$];

    bit trunc_mode;          // bench copy of the rounding mode register
    int send_idle_pct;       // chance per cycle the sender holds back
    int recv_stall_pct;      // chance per cycle the receiver stalls
    bit hold_req;            // asks the hold process for a long stall
    int hold_left;
    int mismatch_cnt;
    int cycle_cnt;

    // ------------------------------------------------------------------------
    // Expected fixed value of one float word under a given rounding mode.
    // Zero, NaN and anything negative give 0; +inf saturates high. Normals
    // put 1.frac at an offset of (exponent - MIN_EXP) bits, then either drop
    // the low bits or round to nearest with an exact half going down.
    // ------------------------------------------------------------------------
    function automatic logic [WIDTH-1:0] fixed_of_float(float_word_t w, bit trunc);
        longint     e;
        longint     s;
        longint     k;
        longint     drop;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] q;
        logic [63:0] top;
        top = (64'd1 << WIDTH) - 64'd1;
        if (w.cls == CLS_ZERO || w.cls == CLS_NAN || w.sgn)
            return '0;
        if (w.cls == CLS_INF)
            return '1;
        e = longint'(w.expo);
        if (e < MIN_EXP)
            return '0;
        if (e > MAX_EXP)
            return '1;
        mant = (64'd1 << FRAC_W) | 64'(w.frac);
        s = e - MIN_EXP;
        if (s >= FRAC_W + 1) begin
            k = s - (FRAC_W + 1);
            // bits shifted past 64 mean the value is far over range
            if (FRAC_W + 1 + k > 64)
                return '1;
            q = mant << k;
        end
        else begin
            drop = FRAC_W + 1 - s;
            rem  = mant & ((64'd1 << drop) - 64'd1);
            half = 64'd1 << (drop - 1);
            q    = mant >> drop;
            if (!trunc && rem > half)
                q = q + 64'd1;
        end
        if (q > top)
            return '1;
        return q[WIDTH-1:0];
    endfunction

    // Random word. Most are positive normals near the output window, with the
    // bits below the output LSB often forced to an exact half or its
    // neighbors; the rest are negatives and fully random words.
    function automatic float_word_t random_word();
        float_word_t w;
        int          pick;
        int          drop;
        logic [63:0] mask;
        logic [63:0] half;
        logic [63:0] low;
        pick   = $urandom_range(99);
        w.cls  = CLS_NORMAL;
        w.sgn  = 1'b0;
        w.expo = EXP_W'($urandom);
        w.frac = FRAC_W'($urandom);
        if (pick < 20) begin
            w.cls = class_t'($urandom_range(3));
            w.sgn = 1'($urandom_range(1));
        end
        else if (pick < 30) begin
            w.sgn  = 1'b1;
            w.expo = EXP_W'($urandom_range(MIN_EXP - 3, MAX_EXP + 3));
        end
        else begin
            w.expo = EXP_W'($urandom_range(MIN_EXP - 3, MAX_EXP + 3));
            drop   = FRAC_W + 1 - (int'(w.expo) - MIN_EXP);
            if (drop >= 2 && drop <= FRAC_W) begin
                mask = (64'd1 << drop) - 64'd1;
                half = 64'd1 << (drop - 1);
                case ($urandom_range(3))
                    0: low = half;
                    1: low = half + 64'd1;
                    2: low = half - 64'd1;
                    default: low = 64'(w.frac) & mask;
                endcase
                w.frac = FRAC_W'((64'(w.frac) & ~mask) | low);
            end
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, counter and timeout
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial cycle_cnt = 0;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers pending words. A held request stays on the bus until it
    // is taken; each accepted request queues its predicted fixed value.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_float
        float_word_t nxt;
        float_word_t sent;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end
        else begin
            if (in_ch.valid && in_ch.ready) begin
                sent.cls  = class_t'(in_ch.class_tag);
                sent.sgn  = in_ch.sign_bit;
                sent.expo = in_ch.biased_exponent;
                sent.frac = in_ch.fraction;
                fixed_expected_q = {fixed_expected_q, fixed_of_float(sent, trunc_mode)};
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (float_pending_q.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = float_pending_q.pop_front();
                    in_ch.valid           <= 1'b1;
                    in_ch.class_tag       <= nxt.cls;
                    in_ch.sign_bit        <= nxt.sgn;
                    in_ch.biased_exponent <= nxt.expo;
                    in_ch.fraction        <= nxt.frac;
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long stall counter, armed from the sequence below
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each taken result against the oldest prediction, then
    // picks ready for the next cycle (random stalls, or the long hold).
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : check_fixed
        logic [WIDTH-1:0] want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                if (fixed_expected_q.size() == 0) begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("result %h with no request outstanding",
                                 out_ch.fixed_value);
                    mismatch_cnt <= mismatch_cnt + 1;
                end
                else begin
                    want = fixed_expected_q.pop_front();
                    if (out_ch.fixed_value !== want) begin
                        if (mismatch_cnt < MAX_REPORTS)
                            $display("fixed_value mismatch: expected %h, got %h",
                                     want, out_ch.fixed_value);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers. Queue fills and knob changes happen on the falling
    // edge so they never race the clocked driver and monitor.
    // ------------------------------------------------------------------------
    task automatic queue_word(class_t cls, logic sgn, int expo, int frac);
        float_word_t w;
        w.cls  = cls;
        w.sgn  = sgn;
        w.expo = EXP_W'(expo);
        w.frac = FRAC_W'(frac);
        float_pending_q = {float_pending_q, w};
    endtask

    // Wait until every request is taken and answered, then let the block settle
    task automatic drain();
        @(negedge clk);
        while (float_pending_q.size() != 0 || in_ch.valid ||
               fixed_expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Rounding mode write; only called with the block idle
    task automatic write_mode(bit m);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        trunc_mode  = m;
        @(negedge clk);
    endtask

    task automatic run_random(bit m, int idle, int stall, int n, bit press);
        write_mode(m);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            float_pending_q = {float_pending_q, random_word()};
        if (press) begin
            // sink goes quiet while the sender keeps pushing, so the
            // internal queue fills and input ready must drop
            hold_req = 1'b1;
            @(negedge clk);
            hold_req = 1'b0;
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.class_tag       = CLS_ZERO;
        in_ch.sign_bit        = 1'b0;
        in_ch.biased_exponent = '0;
        in_ch.fraction        = '0;
        out_ch.ready          = 1'b0;
        trunc_mode            = MODE_ROUND;   // register reset value
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        hold_req              = 1'b0;
        mismatch_cnt          = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words in the reset mode (round to nearest, ties down)
        queue_word(CLS_ZERO,   1'b0, 255, 'h7FFFFF);   // zero ignores fields
        queue_word(CLS_ZERO,   1'b1, 0,   0);
        queue_word(CLS_NAN,    1'b0, 200, 'h2A5A5A);   // NaN gives 0
        queue_word(CLS_INF,    1'b0, 0,   0);          // +inf saturates
        queue_word(CLS_INF,    1'b1, 255, 'h7FFFFF);   // -inf gives 0
        queue_word(CLS_NORMAL, 1'b1, 130, 'h123456);   // negative normal
        queue_word(CLS_NORMAL, 1'b0, 0,   0);          // deep underflow
        queue_word(CLS_NORMAL, 1'b0, MIN_EXP - 1, 'h7FFFFF); // just under range
        queue_word(CLS_NORMAL, 1'b0, MIN_EXP, 0);      // exact half at LSB: down
        queue_word(CLS_NORMAL, 1'b0, MIN_EXP, 1);      // just over half: up
        queue_word(CLS_NORMAL, 1'b0, BIAS, 0);         // 1.0
        queue_word(CLS_NORMAL, 1'b0, 130, 'h5A5800);   // exact tie
        queue_word(CLS_NORMAL, 1'b0, 130, 'h5A5801);   // tie plus one
        queue_word(CLS_NORMAL, 1'b0, 130, 'h5A57FF);   // tie minus one
        queue_word(CLS_NORMAL, 1'b0, MAX_EXP - 1, 'h7FFFFF); // exact half below LSB: no carry
        queue_word(CLS_NORMAL, 1'b0, MAX_EXP, 'h7FFFFF); // largest in range
        queue_word(CLS_NORMAL, 1'b0, MAX_EXP, 0);
        queue_word(CLS_NORMAL, 1'b0, MAX_EXP + 1, 0);  // overflow
        queue_word(CLS_NORMAL, 1'b0, 255, 'h7FFFFF);
        queue_word(CLS_NORMAL, 1'b1, 255, 'h7FFFFF);
        queue_word(CLS_NORMAL, 1'b0, 135, 'h555555);
        queue_word(CLS_NORMAL, 1'b0, 120, 'h2AAAAA);
        drain();

        // Random phases: mode flips each time, idling pattern changes
        run_random(MODE_TRUNCATE, 0,  0,  320, 1'b0);   // back to back
        run_random(MODE_ROUND,    86, 0,  300, 1'b0);   // sparse sender
        run_random(MODE_TRUNCATE, 0,  86, 300, 1'b0);   // slow receiver
        run_random(MODE_ROUND,    10, 10, 300, 1'b1);   // light idling + hold
        run_random(MODE_TRUNCATE, 10, 10, 310, 1'b1);

        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
src/f2uf_pkg.sv
src/f2uf_in_if.sv
src/f2uf_out_if.sv
src/f2uf_front.sv
src/f2uf_queue.sv
src/f2uf_back.sv
src/float_to_unsigned_fixed.sv
sim/tb_top.sv
